/* sv/clwc_pkg.sv */
// package for the cubic lattice walk counter
// widths, limits and the binomial table; no dependencies
package clwc_pkg;

    localparam int MAX_STEPS_DEF = 24;
    localparam int COORD_W = 8;
    localparam int STEP_W = 5;
    localparam int COUNT_W = 63;
    localparam int ACC_W = 64;
    localparam int DIST_W = 9;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic setup;
        logic term_init;
        logic term_mul;
        logic term_add;
        logic next_xb;
        logic next_yb;
    } clwc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic valid_case;
        logic part_last;
        logic xb_last;
        logic yb_last;
    } clwc_sts_t;

    // binomial coefficient, evaluated on constant table indexes
    function automatic logic [ACC_W-1:0] binom_f(input int n, input int k);
        logic [ACC_W-1:0] c;
        int kk;
        c = 1;
        kk = k;
        if (k > n) return '0;
        if (kk > n - kk) kk = n - kk;
        for (int i = 0; i < kk; i++)
            c = c * ACC_W'(n - i) / ACC_W'(i + 1);
        return c;
    endfunction

    // binomial table, row n, column k, n and k up to 24; zero beyond that
    function automatic logic [ACC_W-1:0] binom_tab(input logic [4:0] n, input logic [4:0] k);
        logic [ACC_W-1:0] r;
        r = '0;
        for (int a = 0; a < 25; a++)
            for (int b = 0; b <= a; b++)
                if (n == 5'(a) && k == 5'(b)) r = binom_f(a, b);
        return r;
    endfunction

endpackage

/* sv/clwc_if.sv */
// valid/ready channel interface for the walk counter
// depends on nothing; payload width is a parameter
interface clwc_if #(parameter int W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/clwc_ctrl.sv */
// controller state machine for the walk counter
// depends on clwc_pkg
module clwc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output clwc_pkg::clwc_cmd_t  cmd,
    input  clwc_pkg::clwc_sts_t  sts
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_INIT  = 6'b000100,
        S_MUL   = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                state_next = sts.valid_case ? S_INIT : S_OUT;
            end
            S_INIT:
            begin
                cmd.term_init = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.term_mul = 1'b1;
                if (sts.part_last) state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.term_add = 1'b1;
                if (!sts.xb_last)
                begin
                    cmd.next_xb = 1'b1;
                    state_next = S_INIT;
                end
                else if (!sts.yb_last)
                begin
                    cmd.next_yb = 1'b1;
                    state_next = S_INIT;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

/* sv/clwc_dp.sv */
// datapath: offsets, sort, and term accumulation with one multiplier
// depends on clwc_pkg
module clwc_dp #(
    parameter int MAX_STEPS = clwc_pkg::MAX_STEPS_DEF
) (
    input  logic                            clk,
    input  logic [6*clwc_pkg::COORD_W-1:0]  coords,
    input  logic [clwc_pkg::STEP_W-1:0]     steps,
    input  clwc_pkg::clwc_cmd_t             cmd,
    output clwc_pkg::clwc_sts_t             sts,
    output logic [clwc_pkg::COUNT_W-1:0]    walk_count
);
    localparam int DW = clwc_pkg::DIST_W;
    localparam int AW = clwc_pkg::ACC_W;
    // binomials up to 24 choose 12 fit 22 bits
    localparam int FW = 22;
    localparam int HW = 32;
    localparam int PW = HW + FW;

    logic [DW-1:0] da_reg, db_reg, dc_reg;
    logic [4:0] s_reg, dx_reg, dy_reg, nm_reg;
    logic [4:0] xb_reg, yb_reg, left_reg;
    logic [2:0] part_reg;
    logic [AW-1:0] term_reg, total_reg;
    logic [PW-1:0] lo_reg;
    logic mul_hi_reg;
    logic ok_reg;

    function automatic logic [DW-1:0] adiff(input logic [7:0] a, input logic [7:0] b);
        logic signed [DW-1:0] d;
        d = DW'(signed'(b)) - DW'(signed'(a));
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    // sorting network on the three offsets
    logic [DW-1:0] p0, p1, q1, q2, r0, r1;
    logic [DW+1:0] sum3;
    logic [5:0] diff;
    always_comb
    begin
        p0 = (da_reg > db_reg) ? db_reg : da_reg;
        p1 = (da_reg > db_reg) ? da_reg : db_reg;
        q1 = (p1 > dc_reg) ? dc_reg : p1;
        q2 = (p1 > dc_reg) ? p1 : dc_reg;
        r0 = (p0 > q1) ? q1 : p0;
        r1 = (p0 > q1) ? p0 : q1;
        sum3 = (DW+2)'(r0) + (DW+2)'(r1) + (DW+2)'(q2);
        diff = 6'(s_reg) - 6'(sum3);
    end

    // current part and binomial factor
    logic [4:0] part;
    logic [4:0] rest;
    always_comb
    begin
        rest = nm_reg - xb_reg - yb_reg;
        case (part_reg)
            3'd0: part = xb_reg;
            3'd1: part = xb_reg + dx_reg;
            3'd2: part = yb_reg;
            3'd3: part = yb_reg + dy_reg;
            default: part = rest;
        endcase
    end

    logic [AW-1:0] factor;
    logic [FW-1:0] fac;
    assign factor = clwc_pkg::binom_tab(left_reg, part);
    assign fac = factor[FW-1:0];

    // one 32 by 22 multiplier: low half of the term first, then the high half
    logic [HW-1:0] mul_a;
    logic [PW-1:0] mul_p;
    assign mul_a = mul_hi_reg ? term_reg[AW-1:HW] : term_reg[HW-1:0];
    assign mul_p = {{FW{1'b0}}, mul_a} * {{HW{1'b0}}, fac};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            da_reg <= adiff(coords[7:0], coords[31:24]);
            db_reg <= adiff(coords[15:8], coords[39:32]);
            dc_reg <= adiff(coords[23:16], coords[47:40]);
            s_reg <= steps;
        end
        if (cmd.setup)
        begin
            ok_reg <= (32'(s_reg) <= MAX_STEPS) && ((DW+2)'(s_reg) >= sum3) && !diff[0];
            dx_reg <= r0[4:0];
            dy_reg <= r1[4:0];
            nm_reg <= diff[5:1];
            xb_reg <= '0;
            yb_reg <= '0;
            total_reg <= '0;
        end
        if (cmd.term_init)
        begin
            term_reg <= 64'd1;
            left_reg <= s_reg;
            part_reg <= '0;
            mul_hi_reg <= 1'b0;
        end
        if (cmd.term_mul)
        begin
            if (!mul_hi_reg)
            begin
                lo_reg <= mul_p;
                mul_hi_reg <= 1'b1;
            end
            else
            begin
                term_reg <= {mul_p[HW-1:0], {HW{1'b0}}} + {{(AW-PW){1'b0}}, lo_reg};
                left_reg <= left_reg - part;
                part_reg <= part_reg + 3'd1;
                mul_hi_reg <= 1'b0;
            end
        end
        if (cmd.term_add)
            total_reg <= total_reg + term_reg;
        if (cmd.next_xb)
            xb_reg <= xb_reg + 5'd1;
        if (cmd.next_yb)
        begin
            xb_reg <= '0;
            yb_reg <= yb_reg + 5'd1;
        end
    end

    assign sts.valid_case = (32'(s_reg) <= MAX_STEPS) && ((DW+2)'(s_reg) >= sum3) && !diff[0];
    assign sts.part_last = (part_reg == 3'd4) && mul_hi_reg;
    assign sts.xb_last = (xb_reg == nm_reg - yb_reg);
    assign sts.yb_last = (yb_reg == nm_reg);
    assign walk_count = ok_reg ? total_reg[clwc_pkg::COUNT_W-1:0] : '0;
endmodule

/* sv/cubic_lattice_walk_counter.sv */
// top level of the cubic lattice walk counter
// depends on clwc_pkg, clwc_if, clwc_ctrl, clwc_dp
//
// counts the walks of step_count unit steps on the simple cubic lattice from
// the start point to the end point. one item at a time: load and sort the
// offsets, then for each multinomial term start the term, take five binomial
// factors from a constant table that each take two passes through one shared
// 32 by 22 bit multiplier, then add; then offer the result until it is taken.
// with nm = (s - offset sum)/2 there are (nm+1)(nm+2)/2 terms, the most for
// 24 steps with start equal to end. unreachable, wrong-parity or too-long
// queries skip the terms and give 0.
module cubic_lattice_walk_counter #(
    parameter int MAX_STEPS = clwc_pkg::MAX_STEPS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    clwc_if.sink   in_ch,
    clwc_if.source out_ch
);
    clwc_pkg::clwc_cmd_t cmd;
    clwc_pkg::clwc_sts_t sts;

    // controller sequences setup, factor multiplies and term adds
    clwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // payload: start x,y,z then end x,y,z then step count
    clwc_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .clk        (clk),
        .coords     (in_ch.data[6*clwc_pkg::COORD_W-1:0]),
        .steps      (in_ch.data[6*clwc_pkg::COORD_W +: clwc_pkg::STEP_W]),
        .cmd        (cmd),
        .sts        (sts),
        .walk_count (out_ch.data)
    );
endmodule
